FILE: rtl/core/assert_macros.svh
// Assertion macros for the checker file of this block.
// Depends on nothing; taken in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PBAS_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pbas assertion failed");

// Next-cycle implication, disabled while reset is low.
`define PBAS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pbas assertion failed");

`endif

FILE: rtl/core/pbas_pkg.sv
// Package of the priority batch admission scheduler: sizes, codes and item types.
// Used by every module of the block; depends on nothing.
package pbas_pkg;

  localparam int Slots   = 32;
  localparam int SlotW   = 5;
  localparam int CntW    = 6;
  localparam int PrioW   = 16;
  localparam int PosW    = 16;
  localparam int QuotW   = 32;
  localparam int SumW    = 40;

  // Command codes
  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_SELECT = 2'd1;
  localparam logic [1:0] FUNC_ADAPT  = 2'd2;

  // Slot status codes
  localparam logic [1:0] ST_WAIT    = 2'd0;
  localparam logic [1:0] ST_RUN     = 2'd1;
  localparam logic [1:0] ST_PREEMPT = 2'd2;

  // Register indexes
  localparam logic REG_BATCH_LIMIT  = 1'b0;
  localparam logic REG_SLOTS_IN_USE = 1'b1;

  localparam logic [31:0] LcgMul  = 32'd1103515245;
  localparam logic [31:0] LcgInc  = 32'd12345;
  localparam logic [31:0] LcgSeed = 32'hDEADBEEF;
  localparam logic signed [PrioW-1:0] HalfPrio = 16'sd128;
  localparam logic [CntW-1:0] BatchLimitReset = 6'd32;

  typedef struct packed {
    logic [1:0]              func;
    logic [SlotW-1:0]        slot;
    logic [1:0]              new_status;
    logic signed [PrioW-1:0] new_priority;
    logic [PosW-1:0]         new_position;
    logic [PosW-1:0]         new_length;
  } cmd_t;

  typedef struct packed {
    logic [31:0]      running_bits;
    logic [63:0]      status_vector;
    logic [CntW-1:0]  admitted_count;
    logic             did_preempt;
    logic [SlotW-1:0] victim_slot;
    logic             did_reselect;
  } res_t;

  typedef struct packed {
    logic signed [PrioW-1:0] prio;
    logic [PosW-1:0]         pos;
    logic [PosW-1:0]         len;
  } entry_t;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [QuotW-1:0]  dividend;
    logic [PosW-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QuotW-1:0] quot;
  } div_rsp_t;

endpackage

FILE: rtl/core/pbas_div.sv
// Restoring divider, one quotient bit per cycle, for slot progress.
// Depends on pbas_pkg.
module pbas_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pbas_pkg::div_req_t  req_i,
  output pbas_pkg::div_rsp_t  rsp_o
);

  logic                         busy_q;
  logic                         done_q;
  logic [4:0]                   step_q;
  logic [pbas_pkg::PosW-1:0]    rem_q;
  logic [pbas_pkg::QuotW-1:0]   quo_q;
  logic [pbas_pkg::PosW-1:0]    dvs_q;
  logic [pbas_pkg::PosW:0]      trial;
  logic [pbas_pkg::PosW:0]      diff;
  logic                         qbit;

  // One trial subtraction per step
  always_comb begin
    trial = {rem_q, quo_q[pbas_pkg::QuotW-1]};
    diff  = trial - {1'b0, dvs_q};
    qbit  = (trial >= {1'b0, dvs_q});
  end

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 5'd1;
        if (step_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= qbit ? diff[pbas_pkg::PosW-1:0] : trial[pbas_pkg::PosW-1:0];
      quo_q <= {quo_q[pbas_pkg::QuotW-2:0], qbit};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

FILE: rtl/core/priority_batch_admission_scheduler_core.sv
// Top level of the priority batch admission scheduler: slot table, sequencer, APB registers.
// Depends on pbas_pkg and pbas_div.
//
// Items are taken on start_i while busy_o is low. A write item stores one slot in its
// accept cycle and gives no result. A select or adaptive round gives one result on
// res_o, shown for exactly one cycle with res_valid_o; the receiver cannot stall it,
// so it must take it then. Rounds run on one sequencer that walks the examined slots
// (n = min(slots_in_use, 32)) one per cycle through a registered table read, save
// where the progress pass waits on the divider. Select first counts the waiting and
// running slots, then finds each rank by a full priority scan followed by an LCG draw
// and test. An adaptive round adds a progress pass, which waits on the bit-serial
// divider for each waiting or running slot with a nonzero length, plus a victim scan
// over the n slots, and then possibly a select. Reset clears neither the slot table
// nor the slot statuses.
module priority_batch_admission_scheduler_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command channel
  input  logic               start_i,
  output logic               busy_o,
  input  pbas_pkg::cmd_t     cmd_i,
  // result channel
  output logic               res_valid_o,
  output pbas_pkg::res_t     res_o,
  // APB register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FEAT = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_VIC  = 4'd3;
  localparam logic [3:0] S_DEC  = 4'd4;
  localparam logic [3:0] S_CNT  = 4'd5;
  localparam logic [3:0] S_PICK = 4'd6;
  localparam logic [3:0] S_DRAW = 4'd7;
  localparam logic [3:0] S_TEST = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  localparam int CntW  = pbas_pkg::CntW;
  localparam int SlotW = pbas_pkg::SlotW;

  // Registers
  logic [CntW-1:0]  limit_q, slots_q;
  logic [3:0]       state_q, state_d;
  logic [1:0]       status_q [pbas_pkg::Slots];
  logic [1:0]       status_d [pbas_pkg::Slots];
  pbas_pkg::entry_t mem [pbas_pkg::Slots];
  pbas_pkg::entry_t rd_q;
  logic [31:0]      mask_q, mask_d;
  logic [31:0]      lcg_q, lcg_d;
  logic [31:0]      ranked_q, ranked_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  run_q, run_d;
  logic [CntW-1:0]  wcnt_q, wcnt_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [pbas_pkg::SumW-1:0] sum_q, sum_d;
  logic             found_q, found_d;
  logic [SlotW-1:0] low_q, low_d;
  logic signed [pbas_pkg::PrioW-1:0] lowp_q, lowp_d;
  logic             bestf_q, bestf_d;
  logic [SlotW-1:0] best_q, best_d;
  logic signed [pbas_pkg::PrioW-1:0] bestp_q, bestp_d;
  logic [CntW-1:0]  rank_q, rank_d;
  logic [CntW-1:0]  take_q, take_d;
  logic [CntW-1:0]  avail_q, avail_d;
  logic [CntW-1:0]  adm_q, adm_d;
  logic             pre_q, pre_d;
  logic [SlotW-1:0] vic_q, vic_d;
  logic             resel_q, resel_d;
  logic             res_valid_q, res_valid_d;
  pbas_pkg::res_t   res_q, res_d;

  // Combinational helpers
  logic [CntW-1:0]  n_slots;
  logic [SlotW-1:0] idx_slot;
  logic [1:0]       st_cur;
  logic             last;
  logic             accept;
  logic             mem_we;
  logic             cfg_we;
  logic [CntW-1:0]  w_nx, r_nx;
  logic signed [CntW:0] avail_s;
  logic [9:0]       run10, lim9;
  logic             overload, far_along, low_load;
  logic [39:0]      draw_lhs, draw_rhs;
  logic [8:0]       w10, w9;
  logic [7:0]       i3;
  logic [63:0]      sv;
  logic [31:0]      run_set;
  pbas_pkg::div_req_t div_req;
  pbas_pkg::div_rsp_t div_rsp;

  pbas_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign accept   = start_i && (state_q == S_IDLE);
  assign busy_o   = (state_q != S_IDLE);
  assign n_slots  = (slots_q > CntW'(pbas_pkg::Slots)) ? CntW'(pbas_pkg::Slots) : slots_q;
  assign idx_slot = idx_q[SlotW-1:0];
  assign st_cur   = status_q[idx_slot];
  assign last     = ({1'b0, idx_q} + 7'd1) >= {1'b0, n_slots};
  assign mem_we   = accept && (cmd_i.func == pbas_pkg::FUNC_WRITE);

  // APB registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == pbas_pkg::REG_SLOTS_IN_USE) ? {26'd0, slots_q} : {26'd0, limit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= pbas_pkg::BatchLimitReset;
      slots_q <= '0;
    end else if (cfg_we) begin
      if (paddr[2] == pbas_pkg::REG_BATCH_LIMIT) begin
        limit_q <= pwdata[CntW-1:0];
      end else begin
        slots_q <= pwdata[CntW-1:0];
      end
    end
  end

  // Slot table: written by write items, read one entry a cycle by the sequencer
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cmd_i.slot] <= '{prio: cmd_i.new_priority, pos: cmd_i.new_position,
                           len: cmd_i.new_length};
    end
    rd_q <= mem[idx_d[SlotW-1:0]];
  end

  // Parallel views of the status flops over the examined slots
  always_comb begin
    for (int j = 0; j < pbas_pkg::Slots; j++) begin
      run_set[j]       = (CntW'(j) < n_slots) && (status_q[j] == pbas_pkg::ST_RUN);
      sv[2*j +: 2]     = (CntW'(j) < n_slots) ? status_q[j] : 2'b00;
    end
  end

  // Round features
  always_comb begin
    run10     = 10'(run_q) * 10'd10;
    lim9      = 10'(limit_q) * 10'd9;
    overload  = (run10 > lim9) && (run_q > (limit_q >> 1));
    low_load  = ({run_q, 1'b0} < {1'b0, limit_q});
    far_along = (cnt_q != '0) &&
                (({sum_q[pbas_pkg::SumW-3:0], 2'b00} + sum_q) >
                 {16'd0, cnt_q, 18'd0});
    w_nx      = wcnt_q + CntW'(st_cur == pbas_pkg::ST_WAIT);
    r_nx      = run_q + CntW'(st_cur == pbas_pkg::ST_RUN);
    avail_s   = $signed({1'b0, limit_q}) - $signed({1'b0, r_nx});
    w10       = 9'(wcnt_q) * 9'd10;
    w9        = 9'(wcnt_q) * 9'd9;
    i3        = 8'(rank_q) * 8'd3;
    draw_lhs  = {9'd0, lcg_q[30:0]} * {31'd0, w10};
    draw_rhs  = {(w9 - {1'b0, i3}), 31'd0};
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    mask_d   = mask_q;
    lcg_d    = lcg_q;
    ranked_d = ranked_q;
    idx_d    = idx_q;
    run_d    = run_q;
    wcnt_d   = wcnt_q;
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    found_d  = found_q;
    low_d    = low_q;
    lowp_d   = lowp_q;
    bestf_d  = bestf_q;
    best_d   = best_q;
    bestp_d  = bestp_q;
    rank_d   = rank_q;
    take_d   = take_q;
    avail_d  = avail_q;
    adm_d    = adm_q;
    pre_d    = pre_q;
    vic_d    = vic_q;
    resel_d  = resel_q;
    res_valid_d = 1'b0;
    res_d    = res_q;
    div_req  = '{start: 1'b0, dividend: {rd_q.pos, 16'd0}, divisor: rd_q.len};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d   = '0;
          run_d   = '0;
          wcnt_d  = '0;
          cnt_d   = '0;
          sum_d   = '0;
          found_d = 1'b0;
          adm_d   = '0;
          pre_d   = 1'b0;
          vic_d   = '0;
          resel_d = 1'b0;
          unique case (cmd_i.func)
            pbas_pkg::FUNC_WRITE: begin
              status_d[cmd_i.slot] = cmd_i.new_status;
            end
            pbas_pkg::FUNC_SELECT: begin
              if (n_slots == '0) begin
                mask_d  = '0;
                state_d = S_OUT;
              end else begin
                state_d = S_CNT;
              end
            end
            pbas_pkg::FUNC_ADAPT: begin
              state_d = (n_slots == '0) ? S_OUT : S_FEAT;
            end
            default: ;
          endcase
        end
      end

      // Progress sum over waiting and running slots
      S_FEAT: begin
        if (st_cur == pbas_pkg::ST_WAIT || st_cur == pbas_pkg::ST_RUN) begin
          cnt_d = cnt_q + CntW'(1);
          run_d = r_nx;
        end
        if ((st_cur == pbas_pkg::ST_WAIT || st_cur == pbas_pkg::ST_RUN) &&
            rd_q.len != '0) begin
          div_req.start = 1'b1;
          state_d = S_DIV;
        end else begin
          if (st_cur == pbas_pkg::ST_WAIT || st_cur == pbas_pkg::ST_RUN) begin
            sum_d = sum_q + pbas_pkg::SumW'(32'd65536);
          end
          if (last) begin
            idx_d = '0;
            state_d = S_VIC;
          end else begin
            idx_d = idx_q + CntW'(1);
          end
        end
      end

      S_DIV: begin
        if (div_rsp.done) begin
          sum_d = sum_q + pbas_pkg::SumW'(div_rsp.quot);
          if (last) begin
            idx_d = '0;
            state_d = S_VIC;
          end else begin
            idx_d = idx_q + CntW'(1);
            state_d = S_FEAT;
          end
        end
      end

      // Lowest-priority running slot, first on ties
      S_VIC: begin
        if (st_cur == pbas_pkg::ST_RUN && (!found_q || rd_q.prio < lowp_q)) begin
          found_d = 1'b1;
          low_d   = idx_slot;
          lowp_d  = rd_q.prio;
        end
        if (last) begin
          state_d = S_DEC;
        end else begin
          idx_d = idx_q + CntW'(1);
        end
      end

      S_DEC: begin
        if (overload && found_q && (lowp_q < pbas_pkg::HalfPrio)) begin
          status_d[low_q] = pbas_pkg::ST_PREEMPT;
          mask_d[low_q]   = 1'b0;
          pre_d           = 1'b1;
          vic_d           = low_q;
        end
        if (far_along && low_load) begin
          resel_d = 1'b1;
          idx_d   = '0;
          run_d   = '0;
          wcnt_d  = '0;
          state_d = S_CNT;
        end else begin
          state_d = S_OUT;
        end
      end

      // Count waiting and running slots for selection
      S_CNT: begin
        wcnt_d = w_nx;
        run_d  = r_nx;
        if (last) begin
          idx_d = '0;
          if (w_nx == '0) begin
            mask_d  = run_set;
            state_d = S_OUT;
          end else begin
            mask_d = '0;
            if (avail_s <= 0) begin
              state_d = S_OUT;
            end else begin
              avail_d  = avail_s[CntW-1:0];
              take_d   = (w_nx < avail_s[CntW-1:0]) ? w_nx : avail_s[CntW-1:0];
              rank_d   = '0;
              ranked_d = '0;
              bestf_d  = 1'b0;
              state_d  = S_PICK;
            end
          end
        end else begin
          idx_d = idx_q + CntW'(1);
        end
      end

      // Highest-priority unranked waiting slot, lower slot on ties
      S_PICK: begin
        if (st_cur == pbas_pkg::ST_WAIT && !ranked_q[idx_slot] &&
            (!bestf_q || rd_q.prio > bestp_q)) begin
          bestf_d = 1'b1;
          best_d  = idx_slot;
          bestp_d = rd_q.prio;
        end
        if (last) begin
          state_d = S_DRAW;
        end else begin
          idx_d = idx_q + CntW'(1);
        end
      end

      S_DRAW: begin
        lcg_d   = lcg_q * pbas_pkg::LcgMul + pbas_pkg::LcgInc;
        state_d = S_TEST;
      end

      S_TEST: begin
        if ((draw_lhs < draw_rhs) || (rank_q < (avail_q >> 1))) begin
          status_d[best_q] = pbas_pkg::ST_RUN;
          mask_d[best_q]   = 1'b1;
          adm_d            = adm_q + CntW'(1);
        end
        ranked_d[best_q] = 1'b1;
        rank_d  = rank_q + CntW'(1);
        idx_d   = '0;
        bestf_d = 1'b0;
        state_d = ((rank_q + CntW'(1)) == take_q) ? S_OUT : S_PICK;
      end

      S_OUT: begin
        res_valid_d = 1'b1;
        res_d = '{running_bits: mask_q, status_vector: sv, admitted_count: adm_q,
                  did_preempt: pre_q, victim_slot: vic_q, did_reselect: resel_q};
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mask_q      <= '0;
      lcg_q       <= pbas_pkg::LcgSeed;
      res_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      mask_q      <= mask_d;
      lcg_q       <= lcg_d;
      res_valid_q <= res_valid_d;
      idx_q       <= idx_d;
    end
  end

  // Working registers of a round
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    ranked_q <= ranked_d;
    run_q    <= run_d;
    wcnt_q   <= wcnt_d;
    cnt_q    <= cnt_d;
    sum_q    <= sum_d;
    found_q  <= found_d;
    low_q    <= low_d;
    lowp_q   <= lowp_d;
    bestf_q  <= bestf_d;
    best_q   <= best_d;
    bestp_q  <= bestp_d;
    rank_q   <= rank_d;
    take_q   <= take_d;
    avail_q  <= avail_d;
    adm_q    <= adm_d;
    pre_q    <= pre_d;
    vic_q    <= vic_d;
    resel_q  <= resel_d;
    res_q    <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

FILE: rtl/core/pbas_checker.sv
// Port-level checker for the scheduler core, bound to the top level.
// Depends on pbas_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pbas_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input pbas_pkg::cmd_t cmd_i,
  input logic           res_valid_o,
  input pbas_pkg::res_t res_o
);

  // A result is a single-cycle pulse
  `PBAS_ASSERT_NEXT(a_res_pulse, clk_i, rst_ni, res_valid_o, !res_valid_o)

  // The result shows once the round has ended
  `PBAS_ASSERT_IMPL(a_res_idle, clk_i, rst_ni, res_valid_o, !busy_o)

  // A write item completes in its accept cycle
  `PBAS_ASSERT_NEXT(a_write_fast, clk_i, rst_ni, start_i && !busy_o && (cmd_i.func == pbas_pkg::FUNC_WRITE), !busy_o && !res_valid_o)

  // A select round always goes busy
  `PBAS_ASSERT_NEXT(a_select_busy, clk_i, rst_ni, start_i && !busy_o && (cmd_i.func == pbas_pkg::FUNC_SELECT), busy_o)

  // No victim reported without a preemption
  `PBAS_ASSERT_IMPL(a_victim_zero, clk_i, rst_ni, res_valid_o && !res_o.did_preempt, res_o.victim_slot == '0)

endmodule

bind priority_batch_admission_scheduler_core pbas_checker u_pbas_checker (.*);

FILE: test/testbench.sv
// Self-checking testbench for priority_batch_admission_scheduler_core.
// Depends on pbas_pkg and the core; predicts each round result and compares it.
`timescale 1ns / 100ps

module testbench;

  localparam logic [1:0] FUNC_NONE = 2'd3;  // unused command code
  localparam logic [1:0] ST_DONE   = 2'd3;
  localparam int CycleLimit = 10000000;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start_i = 1'b0;
  logic           busy_o;
  pbas_pkg::cmd_t cmd_i = '0;
  logic           res_valid_o;
  pbas_pkg::res_t res_o;
  logic           psel = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite = 1'b0;
  logic [2:0]     paddr = '0;
  logic [31:0]    pwdata = '0;
  logic [31:0]    prdata;
  logic           pready;

  priority_batch_admission_scheduler_core dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor copy of the slot table, batch mask, LCG and registers
  logic [1:0]  tbl_status [pbas_pkg::Slots];
  shortint     tbl_prio [pbas_pkg::Slots];
  bit [15:0]   tbl_pos [pbas_pkg::Slots];
  bit [15:0]   tbl_len [pbas_pkg::Slots];
  bit [31:0]   run_mask;
  bit [31:0]   lcg_model;
  int          cfg_limit;
  int          cfg_slots;

  pbas_pkg::res_t expected_results [$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          gaps_off = 1'b0;

  function automatic int examined();
    return (cfg_slots > pbas_pkg::Slots) ? pbas_pkg::Slots : cfg_slots;
  endfunction

  function automatic int count_running_slots(int n);
    int c;
    c = 0;
    for (int i = 0; i < n; i++) if (tbl_status[i] == pbas_pkg::ST_RUN) c++;
    return c;
  endfunction

  // Rank waiting slots by priority and admit by draw or by rank
  function automatic int rank_and_admit();
    int n, w, avail, take, admitted, key, b;
    int order [pbas_pkg::Slots];
    longint unsigned r, lhs, rhs;
    n = examined();
    w = 0;
    admitted = 0;
    run_mask = '0;
    for (int i = 0; i < n; i++) if (tbl_status[i] == pbas_pkg::ST_WAIT) begin
      order[w] = i;
      w++;
    end
    if (w == 0) begin
      for (int i = 0; i < n; i++) if (tbl_status[i] == pbas_pkg::ST_RUN) run_mask[i] = 1'b1;
      return 0;
    end
    for (int i = 1; i < w; i++) begin
      key = order[i];
      b = i;
      while (b > 0 && tbl_prio[order[b-1]] < tbl_prio[key]) begin
        order[b] = order[b-1];
        b--;
      end
      order[b] = key;
    end
    avail = cfg_limit - count_running_slots(n);
    take = (w < avail) ? w : avail;
    for (int i = 0; i < take; i++) begin
      lcg_model = lcg_model * pbas_pkg::LcgMul + pbas_pkg::LcgInc;
      r = longint'(lcg_model[30:0]);
      lhs = r * 10 * longint'(w);
      rhs = longint'(9 * w - 3 * i) << 31;
      if (lhs < rhs || i < avail / 2) begin
        tbl_status[order[i]] = pbas_pkg::ST_RUN;
        run_mask[order[i]] = 1'b1;
        admitted++;
      end
    end
    return admitted;
  endfunction

  // Apply one accepted item; queue a result for select and adaptive rounds
  function automatic void predict_item(pbas_pkg::cmd_t c);
    int n, running, low, admitted;
    longint unsigned sum, cnt;
    bit found, preempt, reselect, low_load, far_along;
    pbas_pkg::res_t e;
    admitted = 0;
    preempt = 1'b0;
    reselect = 1'b0;
    low = 0;
    if (c.func == pbas_pkg::FUNC_WRITE) begin
      tbl_status[c.slot] = c.new_status;
      tbl_prio[c.slot] = c.new_priority;
      tbl_pos[c.slot] = c.new_position;
      tbl_len[c.slot] = c.new_length;
      return;
    end
    if (c.func == FUNC_NONE) return;
    n = examined();
    if (c.func == pbas_pkg::FUNC_SELECT) begin
      admitted = rank_and_admit();
    end else begin
      running = count_running_slots(n);
      sum = 0;
      cnt = 0;
      for (int i = 0; i < n; i++) if (tbl_status[i] <= pbas_pkg::ST_RUN) begin
        if (tbl_len[i] == 0) sum += 65536;
        else sum += (longint'(tbl_pos[i]) << 16) / longint'(tbl_len[i]);
        cnt++;
      end
      low_load = 2 * running < cfg_limit;
      far_along = cnt > 0 && 5 * sum > 4 * 65536 * cnt;
      if (10 * running > 9 * cfg_limit && running > cfg_limit / 2) begin
        found = 1'b0;
        for (int i = 0; i < n; i++) begin
          if (tbl_status[i] == pbas_pkg::ST_RUN &&
              (!found || tbl_prio[i] < tbl_prio[low])) begin
            low = i;
            found = 1'b1;
          end
        end
        if (found && tbl_prio[low] < pbas_pkg::HalfPrio) begin
          tbl_status[low] = pbas_pkg::ST_PREEMPT;
          run_mask[low] = 1'b0;
          preempt = 1'b1;
        end
      end
      if (far_along && low_load) begin
        admitted = rank_and_admit();
        reselect = 1'b1;
      end
    end
    e = '0;
    e.running_bits = run_mask;
    for (int i = 0; i < n; i++) e.status_vector[2*i +: 2] = tbl_status[i];
    e.admitted_count = admitted[5:0];
    e.did_preempt = preempt;
    e.victim_slot = preempt ? low[4:0] : '0;
    e.did_reselect = reselect;
    expected_results.push_back(e);
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    pbas_pkg::res_t e;
    if (rst_ni && res_valid_o) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", res_o);
      end else begin
        e = expected_results.pop_front();
        if (res_o.running_bits !== e.running_bits || res_o.status_vector !== e.status_vector
            || res_o.admitted_count !== e.admitted_count
            || res_o.did_preempt !== e.did_preempt || res_o.victim_slot !== e.victim_slot
            || res_o.did_reselect !== e.did_reselect) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp mask %h sv %h adm %0d pre %b vic %0d rsel %b",
                     e.running_bits, e.status_vector, e.admitted_count, e.did_preempt,
                     e.victim_slot, e.did_reselect,
                     "\n          got mask %h sv %h adm %0d pre %b vic %0d rsel %b",
                     res_o.running_bits, res_o.status_vector, res_o.admitted_count,
                     res_o.did_preempt, res_o.victim_slot, res_o.did_reselect);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Send one item: optional random gap, then hold start until accepted
  task automatic send_item(pbas_pkg::cmd_t c);
    if (!gaps_off) begin
      while ($urandom_range(99) < 20) begin
        @(negedge clk_i);
        start_i <= 1'b0;
      end
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_item(c);
  endtask

  // Stop sending and wait until every expected result is in and the core is idle
  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, int value);
    drain();
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == pbas_pkg::REG_BATCH_LIMIT) cfg_limit = value & 63;
    else cfg_slots = value & 63;
  endtask

  function automatic pbas_pkg::cmd_t make_write(int s, logic [1:0] st, shortint p, int pos,
                                                int len);
    pbas_pkg::cmd_t c;
    c = '0;
    c.func = pbas_pkg::FUNC_WRITE;
    c.slot = s[4:0];
    c.new_status = st;
    c.new_priority = p;
    c.new_position = pos[15:0];
    c.new_length = len[15:0];
    return c;
  endfunction

  function automatic pbas_pkg::cmd_t make_round(logic [1:0] f);
    pbas_pkg::cmd_t c;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    c = raw[$bits(pbas_pkg::cmd_t)-1:0];
    c.func = f;
    return c;
  endfunction

  // Random item with a mix biased toward interesting rounds
  function automatic pbas_pkg::cmd_t random_item(int n);
    pbas_pkg::cmd_t c;
    logic [63:0] raw;
    int k;
    raw = {$urandom, $urandom};
    c = raw[$bits(pbas_pkg::cmd_t)-1:0];
    k = $urandom_range(99);
    if (k < 50) begin
      c.func = pbas_pkg::FUNC_WRITE;
      if (n > 0 && $urandom_range(3) != 0) c.slot = 5'($urandom_range(n - 1));
      if ($urandom_range(1))
        c.new_status = ($urandom_range(2) == 0) ? pbas_pkg::ST_RUN : pbas_pkg::ST_WAIT;
      if ($urandom_range(1)) c.new_priority = 16'($urandom_range(300) - 100);
      if ($urandom_range(1)) c.new_position = 16'(c.new_length + $urandom_range(50));
    end else if (k < 75) c.func = pbas_pkg::FUNC_SELECT;
    else if (k < 95) c.func = pbas_pkg::FUNC_ADAPT;
    else c.func = FUNC_NONE;
    return c;
  endfunction

  // Every slot gets a known entry, extremes included
  task automatic test_fill_table();
    send_item(make_write(0, pbas_pkg::ST_WAIT, 16'sh7FFF, 65535, 65535));
    send_item(make_write(1, pbas_pkg::ST_RUN, -16'sh8000, 0, 0));
    send_item(make_write(2, pbas_pkg::ST_PREEMPT, shortint'(128), 65535, 1));
    send_item(make_write(3, ST_DONE, shortint'(127), 0, 65535));
    send_item(make_write(4, pbas_pkg::ST_WAIT, 16'sh7FFF, 10, 0));
    for (int i = 5; i < pbas_pkg::Slots; i++)
      send_item(make_write(i, 2'($urandom_range(3)), shortint'($urandom), $urandom,
                           $urandom));
  endtask

  // Select, adaptive and the unused code at the register extremes
  task automatic test_directed_rounds();
    write_reg(pbas_pkg::REG_SLOTS_IN_USE, 8);
    send_item(make_round(pbas_pkg::FUNC_SELECT));
    send_item(make_round(pbas_pkg::FUNC_ADAPT));
    send_item(make_round(FUNC_NONE));
    write_reg(pbas_pkg::REG_BATCH_LIMIT, 0);
    send_item(make_round(pbas_pkg::FUNC_SELECT));
    send_item(make_round(pbas_pkg::FUNC_ADAPT));
    write_reg(pbas_pkg::REG_BATCH_LIMIT, 1);
    for (int i = 0; i < 6; i++)
      send_item(make_write(i, pbas_pkg::ST_RUN, shortint'(i * 40 - 100), 90, 100));
    send_item(make_round(pbas_pkg::FUNC_ADAPT));
    write_reg(pbas_pkg::REG_BATCH_LIMIT, 63);
    write_reg(pbas_pkg::REG_SLOTS_IN_USE, 63);
    send_item(make_round(pbas_pkg::FUNC_SELECT));
    send_item(make_round(pbas_pkg::FUNC_ADAPT));
  endtask

  // Random phases over several register settings
  task automatic test_random_phases();
    int lim, sl, n;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin lim = 32; sl = 32; end
        1: begin lim = 0;  sl = 0;  end
        2: begin lim = 1;  sl = 2;  end
        3: begin lim = 63; sl = 40; end
        default: begin lim = $urandom_range(1, 8); sl = $urandom_range(1, 8); end
      endcase
      write_reg(pbas_pkg::REG_BATCH_LIMIT, lim);
      write_reg(pbas_pkg::REG_SLOTS_IN_USE, sl);
      n = examined();
      gaps_off = (ph == 5);
      for (int i = 0; i < ((n > 8) ? 40 : 110); i++) send_item(random_item(n));
      gaps_off = 1'b0;
    end
  endtask

  initial begin
    cfg_limit = int'(pbas_pkg::BatchLimitReset);
    cfg_slots = 0;
    run_mask = '0;
    lcg_model = pbas_pkg::LcgSeed;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_fill_table();
    test_directed_rounds();
    test_random_phases();
    drain();
    if (mismatches == 0 && expected_results.size() == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule
